// ===== hdl/ppdb_pkg.sv =====
// ============================================================================
// ppdb_pkg
// Shared sizes, codes and types of the point projection depth buffer.
// ============================================================================
package ppdb_pkg;

    // Store geometry
    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int STORE_SIZE = MAX_COLS * MAX_ROWS;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int LIMC_W     = $clog2(MAX_COLS + 1);
    localparam int LIMR_W     = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W     = $clog2(STORE_SIZE);

    // Field widths
    localparam int DEPTH_W   = 17;
    localparam int COORD_W   = 17;
    localparam int CFG_W     = 24;
    localparam int DIM_W     = 11;
    localparam int REG_IDX_W = 3;
    localparam int NUM_W     = 44;   // projection numerator, signed
    localparam int SQ_W      = 35;   // sum of three squares
    localparam int ITER_N    = 17;   // one root bit per step
    localparam int CNT_W     = 5;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_FOCAL_X    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FOCAL_Y    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_COLS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_ROWS = 3'd5;

    // Opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] focal_x;
        logic [CFG_W-1:0] focal_y;
        logic [CFG_W-1:0] center_x;
        logic [CFG_W-1:0] center_y;
        logic [DIM_W-1:0] cols;
        logic [DIM_W-1:0] rows;
    } cam_cfg_t;

    typedef struct packed {
        logic               done;
        logic               hit;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [DEPTH_W-1:0] range_mm;
    } proj_res_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_WB
    } ctl_state_t;

    typedef enum logic [1:0] {
        PS_IDLE,
        PS_MUL,
        PS_SUM,
        PS_ITER
    } proj_state_t;

endpackage

// ===== hdl/ppdb_proj.sv =====
// ============================================================================
// ppdb_proj
// Pinhole projection of one point to a pixel plus its floored range; the two
// divisions and the square root share one bit-per-cycle iteration loop.
// ============================================================================
module ppdb_proj
    import ppdb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [COORD_W-1:0] x,
    input  logic signed [COORD_W-1:0] y,
    input  logic signed [COORD_W-1:0] z,
    input  cam_cfg_t                  cfg,
    output proj_res_t                 res
);

    localparam int REMU_W = LIMC_W + 24;
    localparam int REMV_W = LIMR_W + 24;

    proj_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic done_reg, done_next;

    logic signed [COORD_W-1:0] x_reg, y_reg, z_reg;

    // first stage products
    logic signed [NUM_W-2:0] ua_reg, ub_reg, va_reg, vb_reg;
    logic [2*COORD_W-1:0]    sx_reg, sy_reg, sz_reg;
    logic [LIMC_W+15:0]      limx_u_reg;
    logic [LIMR_W+15:0]      limx_v_reg;

    // iteration state
    logic                 hit_reg;
    logic [REMU_W-1:0]    rem_u_reg, dsh_u_reg;
    logic [REMV_W-1:0]    rem_v_reg, dsh_v_reg;
    logic [COL_W-1:0]     q_u_reg;
    logic [ROW_W-1:0]     q_v_reg;
    logic [SQ_W-1:0]      n_reg;
    logic [DEPTH_W-1:0]   root_reg, mask_reg;

    // combinational helpers
    logic signed [24:0]        fx_s, fy_s, cx_s, cy_s;
    logic signed [COORD_W:0]   ny, nz;
    logic signed [NUM_W-2:0]   m_ua, m_ub, m_va, m_vb;
    logic signed [2*COORD_W-1:0] m_sx, m_sy, m_sz;
    logic [LIMC_W-1:0]         lim_u;
    logic [LIMR_W-1:0]         lim_v;
    logic signed [NUM_W-1:0]   num_u, num_v;
    logic [NUM_W-1:0]          limden_u, limden_v;
    logic                      hit_calc;
    logic [DEPTH_W-1:0]        trial;
    logic [2*DEPTH_W-1:0]      trial_sq;

    always_comb
    begin
        fx_s  = $signed({1'b0, cfg.focal_x});
        fy_s  = $signed({1'b0, cfg.focal_y});
        cx_s  = $signed({1'b0, cfg.center_x});
        cy_s  = $signed({1'b0, cfg.center_y});
        ny    = -$signed({y_reg[COORD_W-1], y_reg});
        nz    = -$signed({z_reg[COORD_W-1], z_reg});
        m_ua  = fx_s * ny;
        m_ub  = cx_s * x_reg;
        m_va  = fy_s * nz;
        m_vb  = cy_s * x_reg;
        m_sx  = x_reg * x_reg;
        m_sy  = y_reg * y_reg;
        m_sz  = z_reg * z_reg;
        lim_u = (32'(cfg.cols) < 32'(MAX_COLS)) ? LIMC_W'(cfg.cols) : LIMC_W'(MAX_COLS);
        lim_v = (32'(cfg.rows) < 32'(MAX_ROWS)) ? LIMR_W'(cfg.rows) : LIMR_W'(MAX_ROWS);

        num_u    = NUM_W'(ua_reg) + NUM_W'(ub_reg);
        num_v    = NUM_W'(va_reg) + NUM_W'(vb_reg);
        limden_u = NUM_W'({limx_u_reg, 8'b0});
        limden_v = NUM_W'({limx_v_reg, 8'b0});
        hit_calc = (x_reg > 0) && (num_u > 0) && (num_v > 0)
                   && ($unsigned(num_u) < limden_u) && ($unsigned(num_v) < limden_v);

        trial    = root_reg | mask_reg;
        trial_sq = trial * trial;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            PS_IDLE:
            begin
                if (start)
                begin
                    state_next = PS_MUL;
                end
            end
            PS_MUL:
            begin
                state_next = PS_SUM;
            end
            PS_SUM:
            begin
                cnt_next   = CNT_W'(ITER_N - 1);
                state_next = PS_ITER;
            end
            PS_ITER:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = PS_IDLE;
                end
            end
            default:
            begin
                state_next = PS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            PS_IDLE:
            begin
                if (start)
                begin
                    x_reg <= x;
                    y_reg <= y;
                    z_reg <= z;
                end
            end
            PS_MUL:
            begin
                ua_reg     <= m_ua;
                ub_reg     <= m_ub;
                va_reg     <= m_va;
                vb_reg     <= m_vb;
                sx_reg     <= $unsigned(m_sx);
                sy_reg     <= $unsigned(m_sy);
                sz_reg     <= $unsigned(m_sz);
                limx_u_reg <= lim_u * x_reg[COORD_W-2:0];
                limx_v_reg <= lim_v * x_reg[COORD_W-2:0];
            end
            PS_SUM:
            begin
                hit_reg   <= hit_calc;
                rem_u_reg <= REMU_W'($unsigned(num_u));
                rem_v_reg <= REMV_W'($unsigned(num_v));
                dsh_u_reg <= REMU_W'({x_reg[COORD_W-2:0], 8'b0}) << (COL_W - 1);
                dsh_v_reg <= REMV_W'({x_reg[COORD_W-2:0], 8'b0}) << (ROW_W - 1);
                n_reg     <= SQ_W'(sx_reg) + SQ_W'(sy_reg) + SQ_W'(sz_reg);
                root_reg  <= '0;
                mask_reg  <= DEPTH_W'(1) << (ITER_N - 1);
            end
            PS_ITER:
            begin
                // restoring division, quotient bits high to low
                if (cnt_reg < CNT_W'(COL_W))
                begin
                    if (rem_u_reg >= dsh_u_reg)
                    begin
                        rem_u_reg <= rem_u_reg - dsh_u_reg;
                        q_u_reg   <= {q_u_reg[COL_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q_u_reg   <= {q_u_reg[COL_W-2:0], 1'b0};
                    end
                    dsh_u_reg <= dsh_u_reg >> 1;
                end
                if (cnt_reg < CNT_W'(ROW_W))
                begin
                    if (rem_v_reg >= dsh_v_reg)
                    begin
                        rem_v_reg <= rem_v_reg - dsh_v_reg;
                        q_v_reg   <= {q_v_reg[ROW_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q_v_reg   <= {q_v_reg[ROW_W-2:0], 1'b0};
                    end
                    dsh_v_reg <= dsh_v_reg >> 1;
                end
                // keep the trial root bit when its square still fits
                if (SQ_W'(trial_sq) <= n_reg)
                begin
                    root_reg <= trial;
                end
                mask_reg <= mask_reg >> 1;
            end
            default:
            begin
            end
        endcase
    end

    assign res.done     = done_reg;
    assign res.hit      = hit_reg;
    assign res.row      = q_v_reg;
    assign res.col      = q_u_reg;
    assign res.range_mm = root_reg;

endmodule

// ===== hdl/point_projection_depth_buffer_unit.sv =====
// ============================================================================
// point_projection_depth_buffer_unit
// Range image builder: projects lidar points through a pinhole camera model
// and keeps the nearest range per pixel in an on-chip depth store.
// ============================================================================
//
//  channel   handshake            payload
//  -------   ------------------   ----------------------------------------
//  command   start & !busy        opcode, point_x/y/z, read_row, read_col
//  result    done (one cycle)     depth_mm, depth_valid, point_accepted
//  config    wr_en                wr_index, wr_data
//
//  Order of work: an insert that lands passes capture, products and
//  sums, then 17 steps of the shared root/divide loop (one root bit a
//  step sets the count), then a store read and a write-back. An insert
//  that misses the image skips the store. A read inside the store goes
//  through the store read; a read outside it and opcode 3 answer without
//  it. A clear sweeps every store entry (STORE_SIZE, 1,048,576 of them),
//  one a cycle. The same sweep runs after reset with busy high and no
//  result. One word is in flight at a time; the receiver cannot stall, so
//  each result shows for exactly one cycle.
//
module point_projection_depth_buffer_unit
    import ppdb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 opcode,
    input  logic signed [COORD_W-1:0]  point_x,
    input  logic signed [COORD_W-1:0]  point_y,
    input  logic signed [COORD_W-1:0]  point_z,
    input  logic [9:0]                 read_row,
    input  logic [9:0]                 read_col,
    output logic                       done,
    output logic [DEPTH_W-1:0]         depth_mm,
    output logic                       depth_valid,
    output logic                       point_accepted,
    input  logic                       wr_en,
    input  logic [REG_IDX_W-1:0]       wr_index,
    input  logic [CFG_W-1:0]           wr_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cam_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x  <= CFG_W'(128000);
            cfg_reg.focal_y  <= CFG_W'(128000);
            cfg_reg.center_x <= CFG_W'(81920);
            cfg_reg.center_y <= CFG_W'(61440);
            cfg_reg.cols     <= DIM_W'(640);
            cfg_reg.rows     <= DIM_W'(480);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_FOCAL_X:    cfg_reg.focal_x  <= wr_data;
                REG_FOCAL_Y:    cfg_reg.focal_y  <= wr_data;
                REG_CENTER_X:   cfg_reg.center_x <= wr_data;
                REG_CENTER_Y:   cfg_reg.center_y <= wr_data;
                REG_IMAGE_COLS: cfg_reg.cols     <= wr_data[DIM_W-1:0];
                REG_IMAGE_ROWS: cfg_reg.rows     <= wr_data[DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Projection and range unit
    // ------------------------------------------------------------------
    logic      proj_start;
    proj_res_t pres;

    ppdb_proj u_proj (
        .clk   (clk),
        .rst_n (rst_n),
        .start (proj_start),
        .x     (point_x),
        .y     (point_y),
        .z     (point_z),
        .cfg   (cfg_reg),
        .res   (pres)
    );

    // ------------------------------------------------------------------
    // Depth store: {valid, depth} per pixel, one write and one read port
    // ------------------------------------------------------------------
    logic [DEPTH_W:0]  mem [STORE_SIZE];
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [DEPTH_W:0]  mem_wdata;
    logic [DEPTH_W:0]  rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    ctl_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clr_op_reg, clr_op_next;
    logic [1:0]        op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [DEPTH_W-1:0] range_reg, range_next;

    logic               done_reg, done_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               dvalid_reg, dvalid_next;
    logic               accepted_reg, accepted_next;

    logic               read_in_store;
    logic [ADDR_W-1:0]  read_addr, proj_addr;
    logic [DEPTH_W-1:0] old_depth, new_depth;
    logic               old_valid;

    always_comb
    begin
        read_in_store = (32'(read_row) < 32'(MAX_ROWS)) && (32'(read_col) < 32'(MAX_COLS));
        read_addr = ADDR_W'(32'(read_row) * 32'(MAX_COLS) + 32'(read_col));
        proj_addr = ADDR_W'(32'(pres.row) * 32'(MAX_COLS) + 32'(pres.col));
        old_valid = rd_data_reg[DEPTH_W];
        old_depth = rd_data_reg[DEPTH_W-1:0];
        // keep the nearer of the stored and the new range
        new_depth = (!old_valid || (range_reg < old_depth)) ? range_reg : old_depth;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_op_next   = clr_op_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        range_next    = range_reg;
        done_next     = 1'b0;
        depth_next    = '0;
        dvalid_next   = 1'b0;
        accepted_next = 1'b0;
        proj_start    = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = read_addr;

        case (state_reg)
            ST_CLEAR:
            begin
                // drop one valid mark per cycle
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(STORE_SIZE - 1))
                begin
                    state_next  = ST_IDLE;
                    done_next   = clr_op_reg;
                    clr_op_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next = opcode;
                    case (opcode)
                        OP_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            clr_op_next  = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        OP_INSERT:
                        begin
                            proj_start = 1'b1;
                            state_next = ST_CALC;
                        end
                        OP_READ:
                        begin
                            if (read_in_store)
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_WB;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_CALC:
            begin
                if (pres.done)
                begin
                    if (pres.hit)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = proj_addr;
                        addr_next  = proj_addr;
                        range_next = pres.range_mm;
                        state_next = ST_WB;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WB:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (op_reg == OP_READ)
                begin
                    dvalid_next = old_valid;
                    depth_next  = old_valid ? old_depth : '0;
                end
                else
                begin
                    mem_we        = 1'b1;
                    mem_wdata     = {1'b1, new_depth};
                    accepted_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            clr_op_reg  <= 1'b0;
            op_reg      <= OP_CLEAR;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_op_reg  <= clr_op_next;
            op_reg      <= op_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        range_reg    <= range_next;
        depth_reg    <= depth_next;
        dvalid_reg   <= dvalid_next;
        accepted_reg <= accepted_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign depth_mm       = depth_reg;
    assign depth_valid    = dvalid_reg;
    assign point_accepted = accepted_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(point_accepted && depth_valid))
        else $error("insert and read flags both set");

    a_depth_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !depth_valid) |-> (depth_mm == '0))
        else $error("depth shown for an unmarked pixel");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ST_WB) || (state_reg == ST_CLEAR)))
        else $error("store written outside sweep or write-back");

    a_proj_owner: assert property (@(posedge clk) disable iff (!rst_n)
        pres.done |-> (state_reg == ST_CALC))
        else $error("projection finished with no insert pending");

    a_wb_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |-> $past(mem_re))
        else $error("write-back without a store read");

endmodule
